// File: hw/rtl/ssobe_pkg.sv
// ============================================================================
// ssobe_pkg
// Shared widths, constants, types and helpers of the stereo sub-octave bass
// enhancer.
// ============================================================================
package ssobe_pkg;

    // Field and state widths.
    localparam int SAMPLE_W  = 24;
    localparam int STATE_W   = 32;
    localparam int PAIR_W    = 2 * SAMPLE_W;
    localparam int ALIGN_W   = STATE_W - SAMPLE_W;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;

    // Datapath widths of the shared multiplier and its accumulator.
    localparam int A_W    = 34;
    localparam int B_W    = 32;
    localparam int MUL_W  = A_W + B_W;
    localparam int PROD_W = 36;
    localparam int TMP_W  = 34;
    localparam int SUM_W  = 37;
    localparam int WIDE_W = 38;
    localparam int DC_W   = 23;

    // Sequencer: multiply steps per channel.
    localparam int STEP_W = 5;
    localparam int STEPS  = 23;

    // Q1.24 unity and two.
    localparam logic [CFG_W-1:0] ONE_Q24 = 25'h100_0000;
    localparam logic [CFG_W:0]   TWO_Q24 = 26'h200_0000;

    // floor(2*e/5) equals floor(e * DC_RECIP / 2^28) for every e up to unity.
    localparam logic [26:0] DC_RECIP = 27'd107374183;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASS_TRIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX         = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Multiplier operand A sources.
    typedef enum logic [2:0] {
        A_ENV,
        A_ABSENV,
        A_X,
        A_E,
        A_TMP,
        A_ACC,
        A_S1,
        A_S2
    } a_sel_t;

    // Multiplier operand B sources.
    typedef enum logic [3:0] {
        B_OME,
        B_E,
        B_DCM,
        B_SG,
        B_RG,
        B_ACC,
        B_BT,
        B_DRY,
        B_WET
    } b_sel_t;

    // Right shift applied to the product.
    typedef enum logic [1:0] {
        SH23,
        SH24,
        SH28,
        SH31
    } sh_sel_t;

    // Operation on the registered product.
    typedef enum logic [3:0] {
        POST_NONE,
        POST_SUM_LOAD,
        POST_SUM_SGN,
        POST_ENV,
        POST_DC,
        POST_TMP_SUMADD,
        POST_TMP_LOAD,
        POST_ACC_INT,
        POST_ACC_SUB,
        POST_ACC_DC,
        POST_S1,
        POST_S2,
        POST_OUT
    } post_t;

    // Micro-operation of one sequencer step.
    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        sh_sel_t sh;
        post_t   post;
    } ctl_t;

    // Saturate a wide signed value to the state format.
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [WIDE_W-1:0] v
    );
        logic [WIDE_W-STATE_W:0] top;
        top = v[WIDE_W-1:STATE_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[STATE_W-1:0];
        end
        else if (v[WIDE_W-1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end
        else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: hw/rtl/stereo_sub_octave_bass_enhancer.sv
// ============================================================================
// stereo_sub_octave_bass_enhancer
// Per-channel sub-octave generator, soft-limited bass integrator, two-stage
// smoothing and dry/wet mix, computed on one shared multiplier.
// ============================================================================
// Sequence: each input transaction runs 23 multiply steps per channel, left
// then right, and leaves the result in the output register.
// Input: one stereo pair at a time, set by the single shared multiplier; a
// waiting result stalls only the final step.
// Reset: rst_n clears the sequencer, the output valid and all filter state,
// and loads the register reset values.
module stereo_sub_octave_bass_enhancer import ssobe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PAIR_W-1:0]    s_axis_tdata,   // left_sample, right_sample
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PAIR_W-1:0]    m_axis_tdata,   // left_out, right_out
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers, all but the bass trim stored already limited to unity
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rg_reg, sg_reg, e_reg, ome_reg, bt_reg, wet_reg, dry_reg;
    logic [CFG_W-1:0] cap_v, ome_cfg, wet_cfg, dry_cfg;
    logic [CFG_W:0]   mix2, dry_full;
    logic             cfg_write;

    // Register writes wait while a pair is in the multiply sequence.
    assign cfg_ready = s_axis_tready;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cap_v    = (cfg_data > ONE_Q24) ? ONE_Q24 : cfg_data;
        ome_cfg  = ONE_Q24 - cap_v;
        mix2     = {cap_v, 1'b0};
        dry_full = TWO_Q24 - mix2;
        wet_cfg  = (mix2 > {1'b0, ONE_Q24}) ? ONE_Q24 : mix2[CFG_W-1:0];
        dry_cfg  = (dry_full > {1'b0, ONE_Q24}) ? ONE_Q24 : dry_full[CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rg_reg  <= ONE_Q24;
            sg_reg  <= '0;
            e_reg   <= ONE_Q24 >> 1;
            ome_reg <= ONE_Q24 >> 1;
            bt_reg  <= ONE_Q24 >> 1;
            wet_reg <= ONE_Q24;
            dry_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROOT_GAIN:   rg_reg <= cap_v;
                CFG_SUB_GAIN:    sg_reg <= cap_v;
                CFG_FILTER_COEF:
                begin
                    e_reg   <= cap_v;
                    ome_reg <= ome_cfg;
                end
                CFG_BASS_TRIM:   bt_reg <= cfg_data;
                CFG_MIX:
                begin
                    wet_reg <= wet_cfg;
                    dry_reg <= dry_cfg;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                ch_reg;
    logic                m_valid_reg;
    logic                last_step, final_step, adv, accept;
    ctl_t                ctl;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign last_step     = (step_reg == STEP_W'(STEPS - 1));
    assign final_step    = last_step && ch_reg;
    // The final step waits while the previous result is still held.
    assign adv = (state_reg == ST_RUN) &&
                 !(final_step && m_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ch_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                        ch_reg    <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (adv)
                    begin
                        if (last_step)
                        begin
                            step_reg <= '0;
                            ch_reg   <= 1'b1;
                            if (ch_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Step decode: operands, shift and the operation on the last product
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl = '{a_sel: A_X, b_sel: B_E, sh: SH24, post: POST_NONE};
        case (step_reg)
            // Envelope low-pass.
            5'd0:  ctl = '{a_sel: A_ENV,    b_sel: B_OME, sh: SH24, post: POST_NONE};
            5'd1:  ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_SUM_LOAD};
            5'd2:  ctl = '{a_sel: A_E,      b_sel: B_DCM, sh: SH28, post: POST_ENV};
            // Sub-octave term plus root term.
            5'd3:  ctl = '{a_sel: A_ABSENV, b_sel: B_SG,  sh: SH24, post: POST_DC};
            5'd4:  ctl = '{a_sel: A_X,      b_sel: B_RG,  sh: SH24, post: POST_SUM_SGN};
            5'd5:  ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_TMP_SUMADD};
            // Integrator and cubic limiter.
            5'd6:  ctl = '{a_sel: A_TMP,    b_sel: B_E,   sh: SH24, post: POST_NONE};
            5'd7:  ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_ACC_INT};
            5'd8:  ctl = '{a_sel: A_ACC,    b_sel: B_ACC, sh: SH31, post: POST_NONE};
            5'd9:  ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_TMP_LOAD};
            5'd10: ctl = '{a_sel: A_TMP,    b_sel: B_ACC, sh: SH31, post: POST_NONE};
            5'd11: ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_TMP_LOAD};
            5'd12: ctl = '{a_sel: A_TMP,    b_sel: B_E,   sh: SH24, post: POST_NONE};
            5'd13: ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_ACC_SUB};
            5'd14: ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_ACC_DC};
            // Trim and two smoothing stages.
            5'd15: ctl = '{a_sel: A_ACC,    b_sel: B_BT,  sh: SH23, post: POST_NONE};
            5'd16: ctl = '{a_sel: A_S1,     b_sel: B_OME, sh: SH24, post: POST_TMP_LOAD};
            5'd17: ctl = '{a_sel: A_TMP,    b_sel: B_E,   sh: SH24, post: POST_SUM_LOAD};
            5'd18: ctl = '{a_sel: A_S2,     b_sel: B_OME, sh: SH24, post: POST_S1};
            5'd19: ctl = '{a_sel: A_S1,     b_sel: B_E,   sh: SH24, post: POST_SUM_LOAD};
            // Dry/wet mix.
            5'd20: ctl = '{a_sel: A_X,      b_sel: B_DRY, sh: SH24, post: POST_S2};
            5'd21: ctl = '{a_sel: A_S2,     b_sel: B_WET, sh: SH24, post: POST_SUM_LOAD};
            5'd22: ctl = '{a_sel: A_X,      b_sel: B_E,   sh: SH24, post: POST_OUT};
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-channel state and working registers
    // ------------------------------------------------------------------
    logic                       was_neg_reg [2];
    logic                       flip_reg    [2];
    logic signed [STATE_W-1:0]  env_reg     [2];
    logic signed [STATE_W-1:0]  integ_reg   [2];
    logic signed [STATE_W-1:0]  s1_reg      [2];
    logic signed [STATE_W-1:0]  s2_reg      [2];
    logic signed [SAMPLE_W-1:0] samp_reg    [2];

    logic signed [PROD_W-1:0]   p_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [TMP_W-1:0]    tmp_reg;
    logic signed [STATE_W-1:0]  acc_reg;
    logic [DC_W-1:0]            dc_reg;
    logic [SAMPLE_W-1:0]        left_res_reg;
    logic [PAIR_W-1:0]          m_data_reg;

    // Current channel views.
    logic signed [STATE_W-1:0]  x_cur, env_cur, integ_cur, s1_cur, s2_cur, abs_env;
    logic                       x_pos;

    assign x_cur     = {samp_reg[ch_reg], {ALIGN_W{1'b0}}};
    assign env_cur   = env_reg[ch_reg];
    assign integ_cur = integ_reg[ch_reg];
    assign s1_cur    = s1_reg[ch_reg];
    assign s2_cur    = s2_reg[ch_reg];
    assign x_pos     = !x_cur[STATE_W-1] && (x_cur != '0);

    // Rectified envelope, the most negative value clamped to the maximum.
    always_comb
    begin
        if (!env_cur[STATE_W-1])
        begin
            abs_env = env_cur;
        end
        else if (env_cur == {1'b1, {(STATE_W-1){1'b0}}})
        begin
            abs_env = {1'b0, {(STATE_W-1){1'b1}}};
        end
        else
        begin
            abs_env = -env_cur;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier with operand selection and output shift
    // ------------------------------------------------------------------
    logic signed [A_W-1:0]    a_op;
    logic signed [B_W-1:0]    b_op;
    logic signed [MUL_W-1:0]  prod, prod_sh;
    logic signed [PROD_W-1:0] p_next;

    always_comb
    begin
        case (ctl.a_sel)
            A_ENV:    a_op = {{(A_W-STATE_W){env_cur[STATE_W-1]}}, env_cur};
            A_ABSENV: a_op = {{(A_W-STATE_W){1'b0}}, abs_env};
            A_X:      a_op = {{(A_W-STATE_W){x_cur[STATE_W-1]}}, x_cur};
            A_E:      a_op = {{(A_W-CFG_W){1'b0}}, e_reg};
            A_TMP:    a_op = tmp_reg;
            A_ACC:    a_op = {{(A_W-STATE_W){acc_reg[STATE_W-1]}}, acc_reg};
            A_S1:     a_op = {{(A_W-STATE_W){s1_cur[STATE_W-1]}}, s1_cur};
            A_S2:     a_op = {{(A_W-STATE_W){s2_cur[STATE_W-1]}}, s2_cur};
            default:  a_op = '0;
        endcase

        case (ctl.b_sel)
            B_OME:   b_op = {{(B_W-CFG_W){1'b0}}, ome_reg};
            B_E:     b_op = {{(B_W-CFG_W){1'b0}}, e_reg};
            B_DCM:   b_op = {{(B_W-27){1'b0}}, DC_RECIP};
            B_SG:    b_op = {{(B_W-CFG_W){1'b0}}, sg_reg};
            B_RG:    b_op = {{(B_W-CFG_W){1'b0}}, rg_reg};
            B_ACC:   b_op = acc_reg;
            B_BT:    b_op = {{(B_W-CFG_W){1'b0}}, bt_reg};
            B_DRY:   b_op = {{(B_W-CFG_W){1'b0}}, dry_reg};
            B_WET:   b_op = {{(B_W-CFG_W){1'b0}}, wet_reg};
            default: b_op = '0;
        endcase

        prod = a_op * b_op;

        case (ctl.sh)
            SH23:    prod_sh = prod >>> 23;
            SH24:    prod_sh = prod >>> 24;
            SH28:    prod_sh = prod >>> 28;
            SH31:    prod_sh = prod >>> 31;
            default: prod_sh = prod;
        endcase

        p_next = prod_sh[PROD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Adders on the registered product
    // ------------------------------------------------------------------
    logic signed [WIDE_W-1:0] p_wide, sum_p, integ_p, acc_sub, acc_dc;
    logic signed [STATE_W-1:0] sum_sat, integ_sat, acc_sub_sat, acc_dc_sat;
    logic signed [SUM_W-1:0]  p_sum;
    logic                     acc_pos;

    always_comb
    begin
        p_wide  = {{(WIDE_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};
        p_sum   = {p_reg[PROD_W-1], p_reg};
        sum_p   = {sum_reg[SUM_W-1], sum_reg} + p_wide;
        integ_p = {{(WIDE_W-STATE_W){integ_cur[STATE_W-1]}}, integ_cur} + p_wide;
        acc_sub = {{(WIDE_W-STATE_W){acc_reg[STATE_W-1]}}, acc_reg} - p_wide;
        acc_pos = !acc_reg[STATE_W-1] && (acc_reg != '0);
        if (acc_pos)
        begin
            acc_dc = {{(WIDE_W-STATE_W){acc_reg[STATE_W-1]}}, acc_reg} -
                     {{(WIDE_W-DC_W){1'b0}}, dc_reg};
        end
        else
        begin
            acc_dc = {{(WIDE_W-STATE_W){acc_reg[STATE_W-1]}}, acc_reg} +
                     {{(WIDE_W-DC_W){1'b0}}, dc_reg};
        end
        sum_sat     = sat_state(sum_p);
        integ_sat   = sat_state(integ_p);
        acc_sub_sat = sat_state(acc_sub);
        acc_dc_sat  = sat_state(acc_dc);
    end

    // Working registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg[0] <= s_axis_tdata[SAMPLE_W-1:0];
            samp_reg[1] <= s_axis_tdata[PAIR_W-1:SAMPLE_W];
        end

        if (adv)
        begin
            p_reg <= p_next;
            case (ctl.post)
                POST_SUM_LOAD:   sum_reg <= p_sum;
                POST_SUM_SGN:    sum_reg <= flip_reg[ch_reg] ? p_sum : -p_sum;
                POST_DC:         dc_reg  <= p_reg[DC_W-1:0];
                POST_TMP_SUMADD: tmp_reg <= sum_p[TMP_W-1:0];
                POST_TMP_LOAD:   tmp_reg <= p_reg[TMP_W-1:0];
                POST_ACC_INT:    acc_reg <= integ_sat;
                POST_ACC_SUB:    acc_reg <= acc_sub_sat;
                POST_ACC_DC:     acc_reg <= acc_dc_sat;
                POST_OUT:
                begin
                    if (ch_reg)
                    begin
                        m_data_reg <= {sum_sat[STATE_W-1:ALIGN_W], left_res_reg};
                    end
                    else
                    begin
                        left_res_reg <= sum_sat[STATE_W-1:ALIGN_W];
                    end
                end
                default: ;
            endcase
        end
    end

    // Filter state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                was_neg_reg[i] <= 1'b0;
                flip_reg[i]    <= 1'b0;
                env_reg[i]     <= '0;
                integ_reg[i]   <= '0;
                s1_reg[i]      <= '0;
                s2_reg[i]      <= '0;
            end
        end
        else if (adv)
        begin
            case (ctl.post)
                POST_ENV:
                begin
                    env_reg[ch_reg] <= sum_sat;
                    // A rising zero crossing toggles the sub-octave flip-flop.
                    if (x_pos)
                    begin
                        if (was_neg_reg[ch_reg])
                        begin
                            flip_reg[ch_reg] <= !flip_reg[ch_reg];
                        end
                        was_neg_reg[ch_reg] <= 1'b0;
                    end
                    else
                    begin
                        was_neg_reg[ch_reg] <= 1'b1;
                    end
                end
                POST_ACC_DC: integ_reg[ch_reg] <= acc_dc_sat;
                POST_S1:     s1_reg[ch_reg]    <= sum_sat;
                POST_S2:     s2_reg[ch_reg]    <= sum_sat;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv && final_step)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: hw/rtl/ssobe_checker.sv
// ============================================================================
// ssobe_checker
// Port-level checks of the stereo sub-octave bass enhancer, bound to the
// top level.
// ============================================================================
module ssobe_checker import ssobe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [PAIR_W-1:0]    s_axis_tdata,   // left_sample, right_sample
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [PAIR_W-1:0]    m_axis_tdata,   // left_out, right_out
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    // The block works on one pair at a time after an input transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a transaction");

    // The input stays busy while the multiply sequence for both channels runs.
    a_busy_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##40 !s_axis_tready)
        else $error("sequence finished too early");

    // A new result appears together with the return to the idle state.
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while the sequencer is still busy");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output transaction changed while stalled");

endmodule

bind stereo_sub_octave_bass_enhancer ssobe_checker u_ssobe_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the stereo sub-octave bass enhancer. Sample pairs go
// in on the slave stream and processed pairs come back on the master stream.
// Each result is compared with a cycle-free model of both channels. A short
// directed table covers the field extremes, the dry path, ignored register
// writes and the gains above unity. Random phases follow, with mixed source
// and sink idling, new register settings per phase, and a long output
// hold-off.
// ============================================================================
module testbench;
    import ssobe_pkg::*;

    // Bench timing and limits.
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PAIRS    = 52;
    localparam int PRESSURE_PAIRS = 30;

    // Fixed-point constants of the enhancer.
    localparam longint UNITY       = 64'sd1 << 24;
    localparam int     GAIN_FRAC   = 24;
    localparam int     TRIM_FRAC   = 23;
    localparam int     STATE_FRAC  = STATE_W - 1;
    localparam longint DC_DIVISOR  = 320;

    // Register indexes past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Register values and sample extremes used by the directed table.
    localparam logic [CFG_W-1:0] REG_ALL_ONES = 25'h1FF_FFFF;
    localparam logic [CFG_W-1:0] REG_HALF     = 25'h080_0000;
    localparam logic [CFG_W-1:0] REG_STRIPES  = 25'h155_5555;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh80_0000;
    localparam logic signed [SAMPLE_W-1:0] S_ONE = 24'sd1;
    localparam logic signed [SAMPLE_W-1:0] S_NEG = -24'sd1;

    // One stereo pair as it travels in tdata: left in the low bits.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } pair_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table: a register write or a sample pair.
    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       index;
        logic [CFG_W-1:0]           value;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] golden_left;
        logic signed [SAMPLE_W-1:0] golden_right;
    } row_t;

    localparam int DIRECTED_ROWS = 34;

    row_t directed_rows [DIRECTED_ROWS] = '{
        // Reset settings: fully wet, coefficient one half.
        '{ROW_ITEM, '0, '0, '0,    '0,    1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MAX, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_NEG, S_ONE, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, '0,    '0,    1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_ONE, S_NEG, 1'b0, '0, '0},
        // Fully dry: every output equals its input.
        '{ROW_CFG,  CFG_MIX, '0, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
        '{ROW_ITEM, '0, '0, '0,    '0,    1'b1, '0,    '0},
        '{ROW_ITEM, '0, '0, S_ONE, S_NEG, 1'b1, S_ONE, S_NEG},
        // Writes past the register list must leave the dry path alone.
        '{ROW_CFG,  IDX_SPARE_LO, REG_ALL_ONES, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  IDX_SPARE_HI, REG_STRIPES,  '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
        // Gains above unity, trim near four, half mix: outputs saturate.
        '{ROW_CFG,  CFG_ROOT_GAIN,   REG_ALL_ONES, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_SUB_GAIN,    REG_ALL_ONES, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_FILTER_COEF, REG_ALL_ONES, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_BASS_TRIM,   REG_ALL_ONES, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_MIX,         REG_HALF,     '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MAX, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, '0,    '0,    1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MIN, 1'b0, '0, '0},
        // Zero gains and a zero coefficient: the envelope, integrator and smoothing state stands still.
        '{ROW_CFG,  CFG_ROOT_GAIN,   '0,      '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_SUB_GAIN,    '0,      '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_FILTER_COEF, '0,      '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_BASS_TRIM,   '0,      '0, '0, 1'b0, '0, '0},
        '{ROW_CFG,  CFG_MIX,         ONE_Q24, '0, '0, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MAX, S_MIN, 1'b0, '0, '0},
        '{ROW_ITEM, '0, '0, S_MIN, S_MAX, 1'b0, '0, '0}
    };

    // Block ports.
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PAIR_W-1:0]    s_axis_tdata  = '0;     // left_sample, right_sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PAIR_W-1:0]    m_axis_tdata;           // left_out, right_out
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;

    // Register copies, loaded with the reset values.
    logic [CFG_W-1:0] root_gain_q = ONE_Q24;
    logic [CFG_W-1:0] sub_gain_q  = '0;
    logic [CFG_W-1:0] coef_q      = 25'h080_0000;
    logic [CFG_W-1:0] trim_q      = 25'h080_0000;
    logic [CFG_W-1:0] mix_q       = ONE_Q24;

    // Per-channel filter state of the model.
    bit     was_neg   [2] = '{1'b0, 1'b0};
    bit     sub_flip  [2] = '{1'b0, 1'b0};
    longint env_lp    [2] = '{0, 0};
    longint bass_int  [2] = '{0, 0};
    longint smooth1   [2] = '{0, 0};
    longint smooth2   [2] = '{0, 0};

    // Results still owed by the block, oldest first.
    pair_t pending_pairs [$];

    // Run control and bookkeeping.
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit pressure_armed = 1'b0;
    bit sink_hold      = 1'b0;
    int stuck_cycles   = 0;
    int mismatch_count = 0;
    int pairs_sent     = 0;
    int pairs_checked  = 0;
    int reg_writes     = 0;

    stereo_sub_octave_bass_enhancer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Exact product shifted right, rounding toward minus infinity.
    function automatic longint mul_floor(input longint a, input longint b, input int sh);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa = 128'(a);
        wb = 128'(b);
        prod = (wa * wb) >>> sh;
        return prod[63:0];
    endfunction

    function automatic longint clamp_to(input longint v, input int bits);
        longint top;
        top = (64'sd1 <<< (bits - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // Gains above unity act as exactly unity.
    function automatic longint unity_cap(input logic [CFG_W-1:0] v);
        longint w;
        w = longint'(v);
        return (w > UNITY) ? UNITY : w;
    endfunction

    // One channel: sub-octave envelope, soft-limited integrator, smoothing, mix.
    function automatic longint bass_channel(input int ch, input longint xs, input longint e,
                                            input longint dc, input longint wet,
                                            input longint dry);
        longint ome;
        longint env;
        longint drive;
        longint acc;
        longint cube;
        longint s1;
        longint s2;
        longint mixed;
        ome = UNITY - e;

        // A rising zero crossing toggles the sub-octave flip-flop.
        if (xs > 0) begin
            if (was_neg[ch]) sub_flip[ch] = !sub_flip[ch];
            was_neg[ch] = 1'b0;
        end
        else begin
            was_neg[ch] = 1'b1;
        end

        env = clamp_to(mul_floor(env_lp[ch], ome, GAIN_FRAC) + mul_floor(xs, e, GAIN_FRAC),
                       STATE_W);
        env_lp[ch] = env;
        drive = mul_floor(clamp_to(env < 0 ? -env : env, STATE_W), unity_cap(sub_gain_q),
                          GAIN_FRAC);
        if (!sub_flip[ch]) drive = -drive;
        drive += mul_floor(xs, unity_cap(root_gain_q), GAIN_FRAC);

        // Leaky integrator with cubic soft limiting and a DC step toward zero.
        acc = clamp_to(bass_int[ch] + mul_floor(drive, e, GAIN_FRAC), STATE_W);
        cube = mul_floor(mul_floor(acc, acc, STATE_FRAC), acc, STATE_FRAC);
        acc = clamp_to(acc - mul_floor(cube, e, GAIN_FRAC), STATE_W);
        if (acc > 0) acc = clamp_to(acc - dc, STATE_W);
        else acc = clamp_to(acc + dc, STATE_W);
        bass_int[ch] = acc;
        drive = mul_floor(acc, longint'(trim_q), TRIM_FRAC);

        // Two smoothing stages, then the dry/wet mix back at sample precision.
        s1 = clamp_to(mul_floor(smooth1[ch], ome, GAIN_FRAC) + mul_floor(drive, e, GAIN_FRAC),
                      STATE_W);
        smooth1[ch] = s1;
        s2 = clamp_to(mul_floor(smooth2[ch], ome, GAIN_FRAC) + mul_floor(s1, e, GAIN_FRAC),
                      STATE_W);
        smooth2[ch] = s2;
        mixed = clamp_to(mul_floor(xs, dry, GAIN_FRAC) + mul_floor(s2, wet, GAIN_FRAC),
                         STATE_W);
        return clamp_to(mixed >>> ALIGN_W, SAMPLE_W);
    endfunction

    function automatic pair_t predict_pair(input pair_t p);
        longint e;
        longint dc;
        longint m2;
        longint wet;
        longint dry;
        longint xl;
        longint xr;
        pair_t  r;
        e   = unity_cap(coef_q);
        dc  = (e <<< (STATE_FRAC - GAIN_FRAC)) / DC_DIVISOR;
        m2  = 2 * unity_cap(mix_q);
        wet = (m2 > UNITY) ? UNITY : m2;
        dry = 2 * UNITY - m2;
        if (dry > UNITY) dry = UNITY;
        xl = longint'(p.left);
        xr = longint'(p.right);
        r.left  = SAMPLE_W'(bass_channel(0, xl <<< ALIGN_W, e, dc, wet, dry));
        r.right = SAMPLE_W'(bass_channel(1, xr <<< ALIGN_W, e, dc, wet, dry));
        return r;
    endfunction

    // Random register value, weighted toward the ends of the range.
    function automatic logic [CFG_W-1:0] pick_reg_value();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ONE_Q24;
            2:       return REG_ALL_ONES;
            3:       return CFG_W'($urandom_range(ONE_Q24, REG_ALL_ONES));
            default: return CFG_W'($urandom_range(0, ONE_Q24));
        endcase
    endfunction

    // Next sample: mostly a slow random walk, with noise, extremes and near-silence.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(
        input logic signed [SAMPLE_W-1:0] prev
    );
        logic signed [SAMPLE_W-1:0] v;
        int walk;
        v = prev;
        case ($urandom_range(9))
            0, 1: v = SAMPLE_W'($urandom());
            2:    v = SAMPLE_W'($urandom_range(0, 64) - 32);
            3:    v = $urandom_range(1) ? S_MAX : S_MIN;
            default: begin
                walk = int'(prev) + int'($urandom_range(0, 1 << 20)) - (1 << 19);
                v = SAMPLE_W'(clamp_to(longint'(walk), SAMPLE_W));
            end
        endcase
        return v;
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endtask

    // Offer one pair; on acceptance store the result it must produce.
    task automatic send_pair(input pair_t pair, input logic typed, input pair_t golden);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= pair;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        golden = typed ? golden : predict_pair(pair);
        if (typed) void'(predict_pair(pair));
        pending_pairs.push_back(golden);
        pairs_sent++;
    endtask

    // Stop offering and wait until every owed result has come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_ROOT_GAIN:   root_gain_q = value;
            CFG_SUB_GAIN:    sub_gain_q  = value;
            CFG_FILTER_COEF: coef_q      = value;
            CFG_BASS_TRIM:   trim_q      = value;
            CFG_MIX:         mix_q       = value;
            default:         ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic randomize_regs();
        write_reg(CFG_ROOT_GAIN, pick_reg_value());
        write_reg(CFG_SUB_GAIN, pick_reg_value());
        write_reg(CFG_FILTER_COEF, pick_reg_value());
        write_reg(CFG_BASS_TRIM, pick_reg_value());
        write_reg(CFG_MIX, pick_reg_value());
        if ($urandom_range(1))
            write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                      CFG_W'($urandom()));
    endtask

    // Output side: check each result transaction, then decide the next ready.
    always @(posedge clk) begin : result_sink
        pair_t got;
        pair_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_pairs.size() == 0) begin
                    log_failure($sformatf("unexpected result %0d / %0d", got.left, got.right));
                end
                else begin
                    want = pending_pairs.pop_front();
                    pairs_checked++;
                    if (got.left !== want.left)
                        log_failure($sformatf("left_out expected %0d, got %0d",
                                              want.left, got.left));
                    if (got.right !== want.right)
                        log_failure($sformatf("right_out expected %0d, got %0d",
                                              want.right, got.right));
                end
            end
            m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long output hold-off so the block backs up and stalls its input.
    initial begin : output_hold
        wait (pressure_armed);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Main stimulus: directed table, random phases, pressure phase.
    initial begin : stimulus
        pair_t stim;
        pair_t golden;
        logic signed [SAMPLE_W-1:0] walk_left;
        logic signed [SAMPLE_W-1:0] walk_right;
        walk_left  = '0;
        walk_right = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].value);
            end
            else begin
                stim.left    = directed_rows[i].left;
                stim.right   = directed_rows[i].right;
                golden.left  = directed_rows[i].golden_left;
                golden.right = directed_rows[i].golden_right;
                send_pair(stim, directed_rows[i].typed, golden);
            end
        end

        // Random phases, cycling through the idling modes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            randomize_regs();
            repeat (PHASE_PAIRS) begin
                walk_left  = next_sample(walk_left);
                walk_right = next_sample(walk_right);
                stim.left  = walk_left;
                stim.right = walk_right;
                send_pair(stim, 1'b0, stim);
            end
        end

        // Back-to-back input while the output is held off.
        wait_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        randomize_regs();
        pressure_armed = 1'b1;
        repeat (PRESSURE_PAIRS) begin
            walk_left  = next_sample(walk_left);
            walk_right = next_sample(walk_right);
            stim.left  = walk_left;
            stim.right = walk_right;
            send_pair(stim, 1'b0, stim);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d stereo pairs with %0d register writes across all idling modes,",
                 pairs_sent, reg_writes);
        $display("including a long output hold-off; %0d results checked, %0d failures.",
                 pairs_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end
        else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ssobe_pkg.sv
hw/rtl/stereo_sub_octave_bass_enhancer.sv
hw/rtl/ssobe_checker.sv
sim/testbench.sv
